// File: hdl/plr_pkg.sv
// Package: shared types and constants of the palette line renderer.
`default_nettype none

package plr_pkg;

    // Display and palette geometry
    localparam int SCREEN_WIDTH = 240;
    localparam int PAL_DEPTH    = 256;
    localparam int PAL_AW       = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;

    // Field codes and fixed values
    localparam logic [2:0]  DISPOSE_RESTORE = 3'd2;
    localparam logic [15:0] COLOR_BLACK     = 16'h0000;

    // Configuration register indexes
    localparam logic CFG_OFFSET_X = 1'b0;
    localparam logic CFG_OFFSET_Y = 1'b1;

    typedef enum logic [1:0] {
        REQ_PAL_WRITE  = 2'd0,
        REQ_LINE_START = 2'd1,
        REQ_PIXEL      = 2'd2,
        REQ_NEW_FILE   = 2'd3
    } req_type_t;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_RECT  = 1'b1
    } kind_t;

    // Unpacked view of one input item
    typedef struct packed {
        req_type_t   req_type;
        logic [7:0]  pal_index;
        logic [15:0] pal_color;
        logic [7:0]  pixel_index;
        logic [15:0] frame_x;
        logic [15:0] frame_y;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic [15:0] line_y;
        logic [2:0]  disposal;
        logic        has_transparency;
        logic [7:0]  transparent_index;
    } plr_in_t;

    // One result on its way to the output; use_pal selects the palette read data
    typedef struct packed {
        kind_t              kind;
        logic signed [17:0] out_x;
        logic signed [17:0] out_y;
        logic [15:0]        rect_width;
        logic [15:0]        rect_height;
        logic [15:0]        out_color;
        logic               use_pal;
    } plr_item_t;

endpackage : plr_pkg

`default_nettype wire

// File: hdl/palette_line_renderer_top.sv
// Top level of the palette line renderer.
`default_nettype none

// Palette line renderer: takes one item per cycle on s_axis (palette write, line
// start, pixel or new file, selected by s_axis_tuser) and emits at most one
// RGB565 pixel write or black rectangle fill per item on m_axis. Sustained rate
// is one item per clock while m_axis_tready stays high; a result passes through
// the palette read and the lookup stage, which load when its item is accepted,
// and then the output register, which loads once it is empty or being drained.
// s_axis_tready drops only when both stages hold a result and m_axis_tready
// is low.
// The palette table is not cleared by reset: a pixel that hits an entry never
// written returns an unspecified color. Write offset_x / offset_y only while idle.
module palette_line_renderer_top (
    input  wire          clk,
    input  wire          rst_n,
    // configuration write port
    input  wire          cfg_we,
    input  wire          cfg_index,
    input  wire [15:0]   cfg_data,
    // input items
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // pal_index[7:0], pal_color[23:8], pixel_index[31:24], frame_x[47:32],
    // frame_y[63:48], frame_width[79:64], frame_height[95:80], line_y[111:96],
    // disposal[114:112], has_transparency[115], transparent_index[123:116]
    input  wire [127:0]  s_axis_tdata,
    // req_type[1:0]
    input  wire [1:0]    s_axis_tuser,
    // results
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // out_x[17:0], out_y[35:18], rect_width[51:36], rect_height[67:52],
    // out_color[83:68]
    output logic [87:0]  m_axis_tdata,
    // kind[0]
    output logic         m_axis_tuser
);
    import plr_pkg::*;

    plr_in_t               item_in;
    plr_item_t             res;
    plr_item_t             out_item;
    logic                  emit;
    logic                  accept;
    logic                  stage_free;
    logic                  pal_wr_en;
    logic                  pal_rd_en;
    logic [PAL_AW-1:0]     pal_addr;
    logic [15:0]           pal_data;

    // Unpack the input item
    always_comb
    begin
        item_in.req_type          = req_type_t'(s_axis_tuser);
        item_in.pal_index         = s_axis_tdata[7:0];
        item_in.pal_color         = s_axis_tdata[23:8];
        item_in.pixel_index       = s_axis_tdata[31:24];
        item_in.frame_x           = s_axis_tdata[47:32];
        item_in.frame_y           = s_axis_tdata[63:48];
        item_in.frame_width       = s_axis_tdata[79:64];
        item_in.frame_height      = s_axis_tdata[95:80];
        item_in.line_y            = s_axis_tdata[111:96];
        item_in.disposal          = s_axis_tdata[114:112];
        item_in.has_transparency  = s_axis_tdata[115];
        item_in.transparent_index = s_axis_tdata[123:116];
    end

    assign s_axis_tready = stage_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    plr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item_in   (item_in),
        .emit      (emit),
        .res       (res),
        .pal_wr_en (pal_wr_en),
        .pal_addr  (pal_addr),
        .pal_rd_en (pal_rd_en)
    );

    plr_palette_ram u_ram (
        .clk     (clk),
        .wr_en   (pal_wr_en),
        .wr_addr (pal_addr),
        .wr_data (item_in.pal_color),
        .rd_en   (pal_rd_en),
        .rd_addr (pal_addr),
        .rd_data (pal_data)
    );

    plr_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept && emit),
        .res_in     (res),
        .pal_data   (pal_data),
        .out_ready  (m_axis_tready),
        .stage_free (stage_free),
        .out_valid  (m_axis_tvalid),
        .out_item   (out_item)
    );

    // Pack the result
    assign m_axis_tdata = {4'd0, out_item.out_color, out_item.rect_height,
                           out_item.rect_width, out_item.out_y, out_item.out_x};
    assign m_axis_tuser = out_item.kind;

endmodule : palette_line_renderer_top

`default_nettype wire

// File: hdl/plr_palette_ram.sv
// Palette color table: one write port, one registered read port.
`default_nettype none

module plr_palette_ram (
    input  wire                       clk,
    input  wire                       wr_en,
    input  wire [plr_pkg::PAL_AW-1:0] wr_addr,
    input  wire [15:0]                wr_data,
    input  wire                       rd_en,
    input  wire [plr_pkg::PAL_AW-1:0] rd_addr,
    output logic [15:0]               rd_data
);
    import plr_pkg::*;

    logic [15:0] mem [PAL_DEPTH];
    logic [15:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : plr_palette_ram

`default_nettype wire

// File: hdl/plr_ctrl.sv
// Frame and line state, offsets, and per-item decode into a pending result.
`default_nettype none

module plr_ctrl (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       cfg_we,
    input  wire                       cfg_index,
    input  wire [15:0]                cfg_data,
    input  wire                       accept,
    input  plr_pkg::plr_in_t          item_in,
    output logic                      emit,
    output plr_pkg::plr_item_t        res,
    output logic                      pal_wr_en,
    output logic [plr_pkg::PAL_AW-1:0] pal_addr,
    output logic                      pal_rd_en
);
    import plr_pkg::*;

    logic [15:0] offset_x_reg;
    logic [15:0] offset_y_reg;
    logic [15:0] prev_x_reg, prev_x_next;
    logic [15:0] prev_y_reg, prev_y_next;
    logic [15:0] prev_w_reg, prev_w_next;
    logic [15:0] prev_h_reg, prev_h_next;
    logic [2:0]  prev_disp_reg, prev_disp_next;
    logic [2:0]  line_disp_reg, line_disp_next;
    logic        transp_on_reg, transp_on_next;
    logic [7:0]  transp_idx_reg, transp_idx_next;
    logic [15:0] line_left_reg, line_left_next;
    logic [16:0] line_row_reg, line_row_next;
    logic [15:0] clip_reg, clip_next;
    logic [15:0] pix_pos_reg, pix_pos_next;

    logic [17:0] off_x_ext;
    logic [17:0] off_y_ext;
    logic [16:0] right_edge;
    logic        pal_in_range;

    assign off_x_ext  = {{2{offset_x_reg[15]}}, offset_x_reg};
    assign off_y_ext  = {{2{offset_y_reg[15]}}, offset_y_reg};
    assign right_edge = {1'b0, item_in.frame_x} + {1'b0, item_in.frame_width};
    assign pal_in_range = ({1'b0, item_in.pal_index} < 9'(PAL_DEPTH));

    // Palette port control
    always_comb
    begin
        pal_wr_en = accept && (item_in.req_type == REQ_PAL_WRITE) && pal_in_range;
        pal_rd_en = accept && (item_in.req_type == REQ_PIXEL);
        pal_addr  = (item_in.req_type == REQ_PAL_WRITE) ? item_in.pal_index[PAL_AW-1:0]
                                                         : item_in.pixel_index[PAL_AW-1:0];
    end

    // Decode of the current item and next state
    always_comb
    begin
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        prev_w_next     = prev_w_reg;
        prev_h_next     = prev_h_reg;
        prev_disp_next  = prev_disp_reg;
        line_disp_next  = line_disp_reg;
        transp_on_next  = transp_on_reg;
        transp_idx_next = transp_idx_reg;
        line_left_next  = line_left_reg;
        line_row_next   = line_row_reg;
        clip_next       = clip_reg;
        pix_pos_next    = pix_pos_reg;

        emit            = 1'b0;
        res.kind        = KIND_PIXEL;
        res.out_x       = off_x_ext + {2'b00, line_left_reg} + {2'b00, pix_pos_reg};
        res.out_y       = off_y_ext + {1'b0, line_row_reg};
        res.rect_width  = 16'd1;
        res.rect_height = 16'd1;
        res.out_color   = COLOR_BLACK;
        res.use_pal     = 1'b0;

        case (item_in.req_type)
            REQ_LINE_START:
            begin
                if (item_in.line_y == 16'd0)
                begin
                    // pending restore-to-background of the previous frame
                    if (prev_disp_reg == DISPOSE_RESTORE)
                    begin
                        emit            = 1'b1;
                        res.kind        = KIND_RECT;
                        res.out_x       = off_x_ext + {2'b00, prev_x_reg};
                        res.out_y       = off_y_ext + {2'b00, prev_y_reg};
                        res.rect_width  = prev_w_reg;
                        res.rect_height = prev_h_reg;
                    end
                    prev_x_next    = item_in.frame_x;
                    prev_y_next    = item_in.frame_y;
                    prev_w_next    = item_in.frame_width;
                    prev_h_next    = item_in.frame_height;
                    prev_disp_next = item_in.disposal;
                end
                // clip the line at the right screen edge
                if (right_edge > 17'(SCREEN_WIDTH))
                begin
                    clip_next = (item_in.frame_x < 16'(SCREEN_WIDTH))
                              ? 16'(SCREEN_WIDTH) - item_in.frame_x : 16'd0;
                end
                else
                begin
                    clip_next = item_in.frame_width;
                end
                line_disp_next  = item_in.disposal;
                transp_on_next  = item_in.has_transparency;
                transp_idx_next = item_in.transparent_index;
                line_left_next  = item_in.frame_x;
                line_row_next   = {1'b0, item_in.frame_y} + {1'b0, item_in.line_y};
                pix_pos_next    = 16'd0;
            end
            REQ_PIXEL:
            begin
                if (pix_pos_reg < clip_reg)
                begin
                    if (transp_on_reg && (item_in.pixel_index == transp_idx_reg))
                    begin
                        emit = (line_disp_reg == DISPOSE_RESTORE);
                    end
                    else
                    begin
                        emit        = 1'b1;
                        res.use_pal = 1'b1;
                    end
                end
                if (pix_pos_reg != 16'hFFFF)
                begin
                    pix_pos_next = pix_pos_reg + 16'd1;
                end
            end
            REQ_NEW_FILE:
            begin
                prev_disp_next = 3'd0;
            end
            default:
            begin
                // palette writes only touch the color table
            end
        endcase
    end

    // Offset registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= 16'd0;
            offset_y_reg <= 16'd0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_OFFSET_X)
            begin
                offset_x_reg <= cfg_data;
            end
            else
            begin
                offset_y_reg <= cfg_data;
            end
        end
    end

    // Frame and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg     <= 16'd0;
            prev_y_reg     <= 16'd0;
            prev_w_reg     <= 16'd0;
            prev_h_reg     <= 16'd0;
            prev_disp_reg  <= 3'd0;
            line_disp_reg  <= 3'd0;
            transp_on_reg  <= 1'b0;
            transp_idx_reg <= 8'd0;
            line_left_reg  <= 16'd0;
            line_row_reg   <= 17'd0;
            clip_reg       <= 16'd0;
            pix_pos_reg    <= 16'd0;
        end
        else if (accept)
        begin
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            prev_w_reg     <= prev_w_next;
            prev_h_reg     <= prev_h_next;
            prev_disp_reg  <= prev_disp_next;
            line_disp_reg  <= line_disp_next;
            transp_on_reg  <= transp_on_next;
            transp_idx_reg <= transp_idx_next;
            line_left_reg  <= line_left_next;
            line_row_reg   <= line_row_next;
            clip_reg       <= clip_next;
            pix_pos_reg    <= pix_pos_next;
        end
    end

endmodule : plr_ctrl

`default_nettype wire

// File: hdl/plr_out.sv
// Lookup stage and output register: merges palette data into the pending result.
`default_nettype none

module plr_out (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 load,
    input  plr_pkg::plr_item_t  res_in,
    input  wire [15:0]          pal_data,
    input  wire                 out_ready,
    output logic                stage_free,
    output logic                out_valid,
    output plr_pkg::plr_item_t  out_item
);
    import plr_pkg::*;

    logic      advance;
    logic      s1_valid_reg, s1_valid_next;
    plr_item_t s1_reg;
    logic      o_valid_reg, o_valid_next;
    plr_item_t o_reg;
    plr_item_t merged;

    // Lookup stage moves on when the output register is empty or being drained
    assign advance    = !o_valid_reg || out_ready;
    assign stage_free = !s1_valid_reg || advance;

    always_comb
    begin
        merged = s1_reg;
        if (s1_reg.use_pal)
        begin
            merged.out_color = pal_data;
        end
        s1_valid_next = stage_free ? load : s1_valid_reg;
        o_valid_next  = advance ? s1_valid_reg : o_valid_reg;
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (stage_free && load)
        begin
            s1_reg <= res_in;
        end
        if (advance && s1_valid_reg)
        begin
            o_reg <= merged;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_item  = o_reg;

endmodule : plr_out

`default_nettype wire

// File: hdl/plr_checker.sv
// Port-level checker for the palette line renderer and its bind.
`default_nettype none

module plr_checker (
    input wire         clk,
    input wire         rst_n,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [87:0]  m_axis_tdata,
    input wire         m_axis_tuser
);
    import plr_pkg::*;

    // No result may be offered once reset has been seen at a clock edge
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

    // A stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                           && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Pixel writes are always one by one
    a_pixel_size: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_PIXEL)
        |-> (m_axis_tdata[51:36] == 16'd1) && (m_axis_tdata[67:52] == 16'd1))
        else $error("pixel write with size other than 1x1");

    // Rectangle fills only restore background
    a_rect_black: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_RECT)
        |-> (m_axis_tdata[83:68] == COLOR_BLACK))
        else $error("rectangle fill not black");

endmodule : plr_checker

bind palette_line_renderer_top plr_checker u_plr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
